### hdl/rbsd_pkg.sv
package rbsd_pkg;

    // Parse phases of the front end
    typedef enum logic [5:0] {
        PH_IDLE    = 6'b000001,
        PH_HEADER  = 6'b000010,
        PH_CMD     = 6'b000100,
        PH_RUNBYTE = 6'b001000,
        PH_LITERAL = 6'b010000,
        PH_DONE    = 6'b100000
    } t_phase;

    localparam logic [7:0] FLAG_LONG  = 8'h08;
    localparam logic [7:0] RUN_BIAS   = 8'd2;
    localparam logic [2:0] HDR_FLAG   = 3'd1;
    localparam logic [2:0] HDR_SIZE0  = 3'd2;
    localparam logic [2:0] HDR_LONG0  = 3'd4;
    localparam logic [2:0] HDR_SHORT1 = 3'd3;
    localparam logic [2:0] HDR_LONG1  = 3'd7;

    // Queue between the parser and the expander
    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    // One output request: len copies of data; len of zero is the empty-stream marker
    typedef struct packed {
        logic [7:0] data;
        logic [7:0] len;
        logic       fin;
        logic       err;
    } t_op;

    // Queue status seen by the expander
    typedef struct packed {
        logic empty;
        t_op  head;
    } t_qstat;

endpackage

### hdl/rbsd_front.sv
module rbsd_front #(
    parameter int SIZE_BITS = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_accept,
    input  logic         i_start_stream,
    input  logic [7:0]   i_in_byte,
    output logic         o_push,
    output rbsd_pkg::t_op o_op
);

    rbsd_pkg::t_phase     r_phase, n_phase, eff_phase;
    logic [2:0]           r_idx, n_idx, eff_idx;
    logic                 r_long, n_long, eff_long;
    logic [SIZE_BITS-1:0] r_rem, n_rem, eff_rem;
    logic [7:0]           r_len, n_len;
    logic                 r_err, n_err, eff_err;
    logic [7:0]           want;
    logic                 finish;
    logic                 push;
    rbsd_pkg::t_op        op;

    always_comb begin
        // a start byte restarts the parse from a cleared state
        eff_phase = i_start_stream ? rbsd_pkg::PH_HEADER : r_phase;
        eff_idx   = i_start_stream ? 3'd0 : r_idx;
        eff_long  = i_start_stream ? 1'b0 : r_long;
        eff_rem   = i_start_stream ? '0 : r_rem;
        eff_err   = i_start_stream ? 1'b0 : r_err;

        n_phase = eff_phase;
        n_idx   = eff_idx;
        n_long  = eff_long;
        n_rem   = eff_rem;
        n_len   = r_len;
        n_err   = eff_err;
        want    = 8'd0;
        finish  = 1'b0;
        push    = 1'b0;
        op      = '{data: i_in_byte, len: 8'd0, fin: 1'b0, err: eff_err};

        case (eff_phase)
            rbsd_pkg::PH_HEADER: begin
                n_idx = eff_idx + 3'd1;
                if (eff_idx == rbsd_pkg::HDR_FLAG) begin
                    n_long = (i_in_byte & rbsd_pkg::FLAG_LONG) != 8'd0;
                end else if (eff_idx >= rbsd_pkg::HDR_SIZE0 &&
                             (!eff_long || eff_idx >= rbsd_pkg::HDR_LONG0)) begin
                    n_rem  = {eff_rem[SIZE_BITS-9:0], i_in_byte};
                    finish = (!eff_long && eff_idx == rbsd_pkg::HDR_SHORT1) ||
                             (eff_long && eff_idx == rbsd_pkg::HDR_LONG1);
                end
                if (finish) begin
                    n_idx = 3'd0;
                    if (n_rem == '0) begin
                        n_phase = rbsd_pkg::PH_DONE;
                        push    = 1'b1;
                        op      = '{data: 8'd0, len: 8'd0, fin: 1'b1, err: eff_err};
                    end else begin
                        n_phase = rbsd_pkg::PH_CMD;
                    end
                end
            end
            rbsd_pkg::PH_CMD: begin
                if (i_in_byte[7]) begin
                    want = 8'd0 - i_in_byte;
                end else begin
                    want = i_in_byte + rbsd_pkg::RUN_BIAS;
                end
                // clamp an overlong command to what is still owed
                if (SIZE_BITS'(want) > eff_rem) begin
                    want  = eff_rem[7:0];
                    n_err = 1'b1;
                end
                n_len   = want;
                n_phase = i_in_byte[7] ? rbsd_pkg::PH_LITERAL : rbsd_pkg::PH_RUNBYTE;
            end
            rbsd_pkg::PH_LITERAL: begin
                push   = 1'b1;
                op.len = 8'd1;
                op.fin = eff_rem == SIZE_BITS'(1);
                n_rem  = eff_rem - SIZE_BITS'(1);
                n_len  = r_len - 8'd1;
                if (op.fin) begin
                    n_phase = rbsd_pkg::PH_DONE;
                end else if (r_len == 8'd1) begin
                    n_phase = rbsd_pkg::PH_CMD;
                end
            end
            rbsd_pkg::PH_RUNBYTE: begin
                push    = 1'b1;
                op.len  = r_len;
                op.fin  = eff_rem == SIZE_BITS'(r_len);
                n_rem   = eff_rem - SIZE_BITS'(r_len);
                n_len   = 8'd0;
                n_phase = op.fin ? rbsd_pkg::PH_DONE : rbsd_pkg::PH_CMD;
            end
            default: begin
                // idle or done: drop the byte
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= rbsd_pkg::PH_IDLE;
            r_idx   <= 3'd0;
            r_long  <= 1'b0;
            r_rem   <= '0;
            r_len   <= 8'd0;
            r_err   <= 1'b0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_long  <= n_long;
            r_rem   <= n_rem;
            r_len   <= n_len;
            r_err   <= n_err;
        end
    end

    assign o_push = i_accept && push;
    assign o_op   = op;

endmodule

### hdl/rbsd_queue.sv
module rbsd_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  rbsd_pkg::t_op    i_op,
    input  logic             i_pop,
    output logic             o_full,
    output rbsd_pkg::t_qstat o_stat
);

    rbsd_pkg::t_op               r_mem [rbsd_pkg::QDEPTH];
    logic [rbsd_pkg::QAW-1:0]    r_wp;
    logic [rbsd_pkg::QAW-1:0]    r_rp;
    logic [rbsd_pkg::QAW:0]      r_cnt;
    logic                        do_push;
    logic                        do_pop;

    assign o_full       = r_cnt == (rbsd_pkg::QAW+1)'(rbsd_pkg::QDEPTH);
    assign o_stat.empty = r_cnt == '0;
    assign o_stat.head  = r_mem[r_rp];
    assign do_push      = i_push && !o_full;
    assign do_pop       = i_pop && !o_stat.empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

### hdl/rbsd_back.sv
module rbsd_back #(
    parameter int LANES = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  rbsd_pkg::t_qstat i_stat,
    output logic             o_pop,
    input  logic             i_out_stall,
    output logic             o_out_valid,
    output logic [31:0]      o_out_bytes,
    output logic [2:0]       o_out_count,
    output logic             o_last,
    output logic             o_overrun_error
);

    localparam int TW = $clog2(LANES + 1);

    logic          r_busy;
    logic [7:0]    r_left;
    logic          r_ovalid;
    logic [31:0]   r_bytes;
    logic [2:0]    r_count;
    logic          r_last;
    logic          r_err;
    logic          can_load;
    logic          load;
    logic [7:0]    cur_left;
    logic          done;
    logic [TW-1:0] take;
    logic [31:0]   n_bytes;

    assign can_load = !r_ovalid || !i_out_stall;
    assign load     = can_load && !i_stat.empty;
    assign cur_left = r_busy ? r_left : i_stat.head.len;
    assign done     = cur_left <= 8'(LANES);
    assign take     = done ? cur_left[TW-1:0] : TW'(LANES);
    assign o_pop    = load && done;

    always_comb begin
        n_bytes = 32'd0;
        for (int j = 0; j < 4; j++) begin
            if (j < LANES && cur_left > 8'(j)) begin
                n_bytes[8*j +: 8] = i_stat.head.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_bytes <= n_bytes;
            r_count <= 3'(take);
            r_last  <= i_stat.head.fin && done;
            r_err   <= i_stat.head.err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_left   <= 8'd0;
            r_ovalid <= 1'b0;
        end else begin
            if (can_load) begin
                r_ovalid <= !i_stat.empty;
            end
            if (load) begin
                // advance through the run one lane group at a time
                r_busy <= !done;
                r_left <= cur_left - 8'(LANES);
            end
        end
    end

    assign o_out_valid     = r_ovalid;
    assign o_out_bytes     = r_bytes;
    assign o_out_count     = r_count;
    assign o_last          = r_last;
    assign o_overrun_error = r_err;

endmodule

### hdl/rle_byte_stream_decoder_unit.sv
// Run-length byte stream decoder. Input bytes are taken one per cycle while the queue
// has room, by the header and command parser, and turned into output requests held in
// a 4-entry queue; the expander drains the queue and emits one result per cycle while
// the output is not stalled, up to LANES bytes of a run (or one literal byte) per result.
// A run of n bytes takes ceil(n/LANES) results. Command and header bytes yield no result
// (bar an empty stream's last one); requests pass the queue and then the output register.
// The declared size is SIZE_BITS wide; a start_stream byte aborts any stream in progress.
module rle_byte_stream_decoder_unit #(
    parameter int LANES     = 4,
    parameter int SIZE_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_start_stream,
    input  logic [7:0]  i_in_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_out_bytes,
    output logic [2:0]  o_out_count,
    output logic        o_last,
    output logic        o_overrun_error
);

    logic             accept;
    logic             push;
    logic             pop;
    logic             full;
    rbsd_pkg::t_op    op;
    rbsd_pkg::t_qstat qstat;

    assign o_in_stall = full;
    assign accept     = i_in_valid && !full;

    rbsd_front #(
        .SIZE_BITS(SIZE_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_start_stream (i_start_stream),
        .i_in_byte      (i_in_byte),
        .o_push         (push),
        .o_op           (op)
    );

    rbsd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (op),
        .i_pop   (pop),
        .o_full  (full),
        .o_stat  (qstat)
    );

    rbsd_back #(
        .LANES(LANES)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_stat          (qstat),
        .o_pop           (pop),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_out_bytes     (o_out_bytes),
        .o_out_count     (o_out_count),
        .o_last          (o_last),
        .o_overrun_error (o_overrun_error)
    );

endmodule
